>>> src/upc_pkg.sv
// Package for the form-urlencoded percent codec.
// Holds the character constants, the pending-escape state type, the queue command type and
// the character helper functions. No dependencies.
`default_nettype none

package upc_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_USCORE  = 8'h5F;

    localparam int UPC_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } pend_t;

    // up to three output bytes for one input byte; last applies to the final one
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        begin
            r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                (c >= 8'h61 && c <= 8'h66);
            return r;
        end
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39)
                r = c[3:0];
            else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                r = c[3:0] + 4'd9;
            else
                r = 4'd0;
            return r;
        end
    endfunction

    function automatic logic passes(input logic [7:0] c);
        logic r;
        begin
            r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h61 && c <= 8'h7A) || c == CH_STAR || c == CH_DASH ||
                c == CH_DOT || c == CH_USCORE;
            return r;
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        begin
            if (v < 4'd10)
                r = 8'h30 + {4'd0, v};
            else
                r = 8'h37 + {4'd0, v};
            return r;
        end
    endfunction

endpackage

`default_nettype wire

>>> src/upc_front.sv
// Front end: accepts input bytes, tracks the pending escape and builds one queue command.
// Depends on upc_pkg.
`default_nettype none

module upc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    input  wire logic          space_ok,
    output logic               in_ready,
    output logic               push,
    output upc_pkg::cmd_t      push_cmd
);

    logic           mode_reg;
    upc_pkg::pend_t pend_reg, pend_next;
    logic [7:0]     digit_reg, digit_next;
    logic           accept;
    logic           f_emit;
    logic [7:0]     f_byte;
    upc_pkg::cmd_t  cmd;

    assign in_ready = space_ok;
    assign accept   = in_valid && space_ok;

    // decode of a byte with nothing held
    always_comb
    begin
        f_emit = 1'b1;
        f_byte = in_byte;
        if (in_byte == upc_pkg::CH_PERCENT)
            f_emit = in_last;
        else if (in_byte == upc_pkg::CH_PLUS)
            f_byte = upc_pkg::CH_SPACE;
    end

    // next state
    always_comb
    begin
        pend_next  = pend_reg;
        digit_next = digit_reg;
        if (accept && mode_reg)
        begin
            case (pend_reg)
                upc_pkg::PEND_PCT:
                begin
                    if (upc_pkg::is_hex(in_byte) && !in_last)
                    begin
                        pend_next  = upc_pkg::PEND_DIGIT;
                        digit_next = in_byte;
                    end
                    else if (!upc_pkg::is_hex(in_byte) && in_byte == upc_pkg::CH_PERCENT
                             && !in_last)
                        pend_next = upc_pkg::PEND_PCT;
                    else
                        pend_next = upc_pkg::PEND_NONE;
                end
                upc_pkg::PEND_DIGIT:
                begin
                    digit_next = 8'd0;
                    if (!upc_pkg::is_hex(in_byte) && in_byte == upc_pkg::CH_PERCENT && !in_last)
                        pend_next = upc_pkg::PEND_PCT;
                    else
                        pend_next = upc_pkg::PEND_NONE;
                end
                default:
                begin
                    if (in_byte == upc_pkg::CH_PERCENT && !in_last)
                        pend_next = upc_pkg::PEND_PCT;
                    else
                        pend_next = upc_pkg::PEND_NONE;
                end
            endcase
        end
    end

    // command output
    always_comb
    begin
        cmd.bytes = '0;
        cmd.cnt   = 2'd0;
        cmd.last  = in_last;
        if (!mode_reg)
        begin
            if (upc_pkg::passes(in_byte))
            begin
                cmd.bytes[0] = in_byte;
                cmd.cnt      = 2'd1;
            end
            else if (in_byte == upc_pkg::CH_SPACE)
            begin
                cmd.bytes[0] = upc_pkg::CH_PLUS;
                cmd.cnt      = 2'd1;
            end
            else
            begin
                cmd.bytes[0] = upc_pkg::CH_PERCENT;
                cmd.bytes[1] = upc_pkg::hex_char(in_byte[7:4]);
                cmd.bytes[2] = upc_pkg::hex_char(in_byte[3:0]);
                cmd.cnt      = 2'd3;
            end
        end
        else
        begin
            case (pend_reg)
                upc_pkg::PEND_PCT:
                begin
                    if (upc_pkg::is_hex(in_byte))
                    begin
                        if (in_last)
                        begin
                            cmd.bytes[0] = upc_pkg::CH_PERCENT;
                            cmd.bytes[1] = in_byte;
                            cmd.cnt      = 2'd2;
                        end
                    end
                    else
                    begin
                        cmd.bytes[0] = upc_pkg::CH_PERCENT;
                        cmd.bytes[1] = f_byte;
                        cmd.cnt      = f_emit ? 2'd2 : 2'd1;
                    end
                end
                upc_pkg::PEND_DIGIT:
                begin
                    if (upc_pkg::is_hex(in_byte))
                    begin
                        cmd.bytes[0] = {upc_pkg::hex_val(digit_reg), upc_pkg::hex_val(in_byte)};
                        cmd.cnt      = 2'd1;
                    end
                    else
                    begin
                        cmd.bytes[0] = upc_pkg::CH_PERCENT;
                        cmd.bytes[1] = digit_reg;
                        cmd.bytes[2] = f_byte;
                        cmd.cnt      = f_emit ? 2'd3 : 2'd2;
                    end
                end
                default:
                begin
                    cmd.bytes[0] = f_byte;
                    cmd.cnt      = f_emit ? 2'd1 : 2'd0;
                end
            endcase
        end
    end

    assign push     = accept && (cmd.cnt != 2'd0);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            pend_reg  <= upc_pkg::PEND_NONE;
            digit_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            mode_reg  <= cfg_wdata;
            pend_reg  <= upc_pkg::PEND_NONE;
            digit_reg <= 8'd0;
        end
        else
        begin
            pend_reg  <= pend_next;
            digit_reg <= digit_next;
        end
    end

    a_encode_holds_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        !mode_reg |-> pend_reg == upc_pkg::PEND_NONE)
        else $error("escape held in encode mode");

    a_encode_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !mode_reg) |-> push)
        else $error("encoded byte produced no output");

endmodule

`default_nettype wire

>>> src/upc_queue.sv
// Short command queue between the front and back ends.
// Depends on upc_pkg.
`default_nettype none

module upc_queue #(
    parameter int DEPTH = upc_pkg::UPC_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire upc_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               space_ok,
    output logic               head_valid,
    output upc_pkg::cmd_t      head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    upc_pkg::cmd_t       mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign space_ok   = count_reg != FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && space_ok;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space_ok)
        else $error("command pushed into full queue");

endmodule

`default_nettype wire

>>> src/upc_back.sv
// Back end: walks the bytes of the head command into the output register.
// Depends on upc_pkg.
`default_nettype none

module upc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire upc_pkg::cmd_t head_cmd,
    output logic               pop,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       vld_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load   = head_valid && (!vld_reg || out_ready);
    assign at_end = idx_reg == (head_cmd.cnt - 2'd1);
    assign pop    = load && at_end;

    always_comb
    begin
        case (idx_reg)
            2'd1:    sel_byte = head_cmd.bytes[1];
            2'd2:    sel_byte = head_cmd.bytes[2];
            default: sel_byte = head_cmd.bytes[0];
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = at_end ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                vld_reg <= 1'b1;
            else if (out_ready)
                vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            last_reg <= at_end && head_cmd.last;
        end
    end

    assign out_valid = vld_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head_cmd.cnt))
        else $error("byte index past command length");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !out_ready) |=> (vld_reg && $stable(byte_reg) && $stable(last_reg)))
        else $error("output register changed while stalled");

endmodule

`default_nettype wire

>>> src/url_percent_codec.sv
// Top level of the streaming form-urlencoded percent codec.
// Instantiates upc_front, upc_queue and upc_back; depends on upc_pkg.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: in_byte[7:0]; tlast: in_last
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: out_byte[7:0]; tlast: out_last
//  cfg       in         cfg_we                       cfg_wdata: decode_mode
//
// One input byte is taken per cycle while the queue has room; it yields 0 to 3 output bytes.
// The output register issues one byte per cycle while m_axis_tready is high; an encoded escape is three output bytes.
// Each command is written into the queue, and its bytes are then loaded into the output register.
// rst_n clears the mode, the pending escape, the queue and the output valid.
// Output stalls back up through the queue to s_axis_tready independently of the front.
`default_nettype none

module url_percent_codec #(
    parameter int QUEUE_DEPTH = upc_pkg::UPC_QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast
);

    logic          space_ok;
    logic          push;
    upc_pkg::cmd_t push_cmd;
    logic          pop;
    logic          head_valid;
    upc_pkg::cmd_t head_cmd;

    upc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .space_ok  (space_ok),
        .in_ready  (s_axis_tready),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    upc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    upc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire
